// ===== sv/scms_pkg.sv =====
// Shared types and constants for the serial cartridge memory slave.
// Used by scms_engine and the top level; no dependencies.
package scms_pkg;

  // Sequencer phase, one-hot
  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_ADDR16 = 6'b000010,
    PH_ADDR24 = 6'b000100,
    PH_STATUS = 6'b001000,
    PH_READ   = 6'b010000,
    PH_WAIT   = 6'b100000
  } phase_t;

  // Command codes
  localparam logic [7:0] CMD_STATUS = 8'h00;
  localparam logic [7:0] CMD_ADDR24 = 8'hA8;
  localparam logic [7:0] CMD_ADDR16 = 8'hA0;
  localparam logic [7:0] CMD_READ_A = 8'hD8;
  localparam logic [7:0] CMD_READ_B = 8'hD0;

  localparam logic [7:0] STATUS_BYTE = 8'h00;

  localparam int         SHIFT_BITS   = 24;
  localparam logic [4:0] CMD_LEN      = 5'd8;
  localparam logic [4:0] ADDR16_LEN   = 5'd16;
  localparam logic [4:0] ADDR24_LEN   = 5'd24;
  localparam logic [4:0] BYTE_LEN     = 5'd8;

  // Per-slot line and status flags of one result
  typedef struct packed {
    logic data_out;
    logic data_drive;
    logic led_on;
    logic error;
  } result_t;

endpackage

// ===== sv/scms_engine.sv =====
// Command sequencer for the serial cartridge memory slave: holds the protocol
// state and works out one bit slot per step. Depends on scms_pkg.
module scms_engine #(
  parameter int ADDR_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic                  command,
  input  logic                  data_in,
  input  logic [7:0]            mem_data,
  output scms_pkg::result_t     result,
  output logic [ADDR_BITS-1:0]  pointer_next
);

  scms_pkg::phase_t phase, phase_next;
  logic [4:0]  bit_count, bit_count_next;
  logic [scms_pkg::SHIFT_BITS-1:0] shift_in, shift_in_next;
  logic [ADDR_BITS-1:0] address_pointer;
  logic [7:0]  tx_byte, tx_byte_next;
  logic        error_flag, error_flag_next;

  logic [scms_pkg::SHIFT_BITS-1:0] shifted;
  logic [4:0]  count_inc;
  logic [7:0]  byte_out;
  logic [4:0]  addr_len;
  logic        dout, drive;

  assign shifted   = {shift_in[scms_pkg::SHIFT_BITS-2:0], data_in};
  assign count_inc = bit_count + 5'd1;
  assign addr_len  = (phase == scms_pkg::PH_ADDR24) ? scms_pkg::ADDR24_LEN
                                                    : scms_pkg::ADDR16_LEN;

  always_comb begin
    phase_next      = phase;
    bit_count_next  = bit_count;
    shift_in_next   = shift_in;
    pointer_next    = address_pointer;
    tx_byte_next    = tx_byte;
    error_flag_next = error_flag;
    byte_out        = tx_byte;
    dout            = 1'b0;
    drive           = 1'b0;

    if (command) begin
      // select released: drop any partial command or address
      phase_next     = scms_pkg::PH_IDLE;
      bit_count_next = '0;
      shift_in_next  = '0;
    end else begin
      unique case (phase)
        scms_pkg::PH_IDLE: begin
          shift_in_next  = shifted;
          bit_count_next = count_inc;
          if (count_inc >= scms_pkg::CMD_LEN) begin
            bit_count_next = '0;
            shift_in_next  = '0;
            unique case (shifted[7:0])
              scms_pkg::CMD_STATUS: phase_next = scms_pkg::PH_STATUS;
              scms_pkg::CMD_ADDR24: phase_next = scms_pkg::PH_ADDR24;
              scms_pkg::CMD_ADDR16: phase_next = scms_pkg::PH_ADDR16;
              scms_pkg::CMD_READ_A,
              scms_pkg::CMD_READ_B: phase_next = scms_pkg::PH_READ;
              default: begin
                error_flag_next = 1'b1;
                phase_next      = scms_pkg::PH_WAIT;
              end
            endcase
          end
        end
        scms_pkg::PH_ADDR16,
        scms_pkg::PH_ADDR24: begin
          shift_in_next  = shifted;
          bit_count_next = count_inc;
          if (count_inc >= addr_len) begin
            pointer_next   = ADDR_BITS'(shifted);
            bit_count_next = '0;
            shift_in_next  = '0;
            phase_next     = scms_pkg::PH_WAIT;
          end
        end
        scms_pkg::PH_STATUS: begin
          if (bit_count == '0) byte_out = scms_pkg::STATUS_BYTE;
          dout           = byte_out[7];
          drive          = 1'b1;
          tx_byte_next   = {byte_out[6:0], 1'b0};
          bit_count_next = count_inc;
          if (count_inc >= scms_pkg::BYTE_LEN) begin
            bit_count_next = '0;
            phase_next     = scms_pkg::PH_WAIT;
          end
        end
        scms_pkg::PH_READ: begin
          // load a fresh byte and post-increment at each byte start
          if (bit_count == '0) begin
            byte_out     = mem_data;
            pointer_next = address_pointer + ADDR_BITS'(1);
          end
          dout           = byte_out[7];
          drive          = 1'b1;
          tx_byte_next   = {byte_out[6:0], 1'b0};
          bit_count_next = count_inc;
          if (count_inc >= scms_pkg::BYTE_LEN) bit_count_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign result.data_out   = dout;
  assign result.data_drive = drive;
  assign result.led_on     = (phase_next != scms_pkg::PH_READ);
  assign result.error      = error_flag_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= scms_pkg::PH_IDLE;
      bit_count       <= '0;
      shift_in        <= '0;
      address_pointer <= '0;
      tx_byte         <= '0;
      error_flag      <= 1'b0;
    end else if (step) begin
      phase           <= phase_next;
      bit_count       <= bit_count_next;
      shift_in        <= shift_in_next;
      address_pointer <= pointer_next;
      tx_byte         <= tx_byte_next;
      error_flag      <= error_flag_next;
    end
  end

endmodule

// ===== sv/serial_cartridge_memory_slave.sv =====
// Top level of the serial cartridge memory slave: input stage, command
// sequencer (scms_engine) and result register. Depends on scms_pkg.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one bus event per
//   transaction: command 0 is one clock bit slot with data_in sampled, command 1
//   is select release. mem_data is the memory byte at the address last shown
//   on mem_address. The output channel (out_valid/out_ready) returns exactly
//   one result per input transaction: data_out/data_drive for the data line,
//   mem_address, led_on and the sticky error flag.
//   An accepted transaction is held in the input register and passes through
//   the sequencer into the result register, which raises out_valid once the
//   result register is empty or being emptied.
//   Throughput is one transaction per cycle while out_ready stays high; the
//   sequencer state updates with each transaction, so consecutive slots follow without gaps.
//   Reset puts the sequencer in the command-wait phase with pointer, counters
//   and error cleared, and empties both registers.
//   When the receiver stalls, the result register holds its transaction and
//   the input register fills; in_ready drops only when both are occupied.
module serial_cartridge_memory_slave #(
  parameter int ADDR_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic        data_in,
  input  logic [7:0]  mem_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        data_out,
  output logic        data_drive,
  output logic [23:0] mem_address,
  output logic        led_on,
  output logic        error
);

  logic       s_valid;
  logic       s_command;
  logic       s_data_in;
  logic [7:0] s_mem_data;
  logic       advance;

  scms_pkg::result_t    result;
  logic [ADDR_BITS-1:0] pointer_next;

  assign advance  = s_valid && (!out_valid || out_ready);
  assign in_ready = !s_valid || advance;

  scms_engine #(
    .ADDR_BITS(ADDR_BITS)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .command      (s_command),
    .data_in      (s_data_in),
    .mem_data     (s_mem_data),
    .result       (result),
    .pointer_next (pointer_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) s_valid <= in_valid;
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_command  <= command;
      s_data_in  <= data_in;
      s_mem_data <= mem_data;
    end
    if (advance) begin
      data_out    <= result.data_out;
      data_drive  <= result.data_drive;
      led_on      <= result.led_on;
      error       <= result.error;
      mem_address <= 24'(pointer_next);
    end
  end

endmodule

// ===== sv/scms_checker.sv =====
// Port-level checks for serial_cartridge_memory_slave, attached by bind.
// No package dependencies.
module scms_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        data_out,
  input logic        data_drive,
  input logic [23:0] mem_address,
  input logic        error
);

  // a stalled result keeps its address, data bit and error flag
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mem_address)
      && $stable(data_out) && $stable(error))
    else $error("stalled result changed");

  // while a result is valid, the line is low whenever it is not driven
  a_idle_line: assert property (@(posedge clk) disable iff (rst)
    out_valid && !data_drive |-> !data_out)
    else $error("data_out high while not driving");

  // error never clears once reported
  a_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |=> !out_valid || error)
    else $error("error flag cleared without reset");

  // with the output empty, an accepted transaction passes through the input and result registers to out_valid
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> ##1 out_valid)
    else $error("result missing after accepted transaction");

endmodule

bind serial_cartridge_memory_slave scms_checker u_scms_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for serial_cartridge_memory_slave: drives bus slots over
// the valid/ready input channel and checks every result against a bit-accurate
// predictor of the command sequencer. Depends on scms_pkg and the RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic       EV_SLOT     = 1'b0;
  localparam logic       EV_RELEASE  = 1'b1;
  // Filesystem commands the block does not serve
  localparam logic [7:0] CMD_LIST    = 8'hF0;
  localparam logic [7:0] CMD_OPEN    = 8'hF1;

  localparam int unsigned RANDOM_ITEMS = 500;
  localparam int unsigned CYCLE_LIMIT  = 400_000;

  typedef struct packed {
    logic        data_out;
    logic        data_drive;
    logic [23:0] mem_address;
    logic        led_on;
    logic        error;
  } slot_result_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        command;
  logic        data_in;
  logic [7:0]  mem_data;
  logic        out_valid;
  logic        out_ready;
  logic        data_out;
  logic        data_drive;
  logic [23:0] mem_address;
  logic        led_on;
  logic        error;

  serial_cartridge_memory_slave uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .data_in     (data_in),
    .mem_data    (mem_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .data_out    (data_out),
    .data_drive  (data_drive),
    .mem_address (mem_address),
    .led_on      (led_on),
    .error       (error)
  );

  // Predicted sequencer state
  scms_pkg::phase_t                bus_phase  = scms_pkg::PH_IDLE;
  logic [4:0]                      slot_count = '0;
  logic [scms_pkg::SHIFT_BITS-1:0] shift_acc  = '0;
  logic [23:0]                     read_ptr   = '0;
  logic [7:0]                      tx_shift   = '0;
  logic                            err_sticky = 1'b0;

  slot_result_t expected_slots[$];

  bit          src_gaps_on    = 1'b1;
  bit          sink_stalls_on = 1'b1;
  int unsigned slots_sent      = 0;
  int unsigned releases_sent   = 0;
  int unsigned ignored_slots   = 0;
  int unsigned addr_loads      = 0;
  int unsigned read_bytes      = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches      = 0;
  int unsigned cycle_count     = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advance the predicted sequencer by one bus event and queue its result
  function automatic void predict_slot(logic kind, logic din, logic [7:0] mem);
    slot_result_t r;
    logic [7:0]   op;
    logic [4:0]   need;
    r = '0;
    if (kind == EV_RELEASE) begin
      bus_phase  = scms_pkg::PH_IDLE;
      slot_count = '0;
      shift_acc  = '0;
    end else begin
      case (bus_phase)
        scms_pkg::PH_IDLE: begin
          shift_acc  = {shift_acc[scms_pkg::SHIFT_BITS-2:0], din};
          slot_count = slot_count + 5'd1;
          if (slot_count >= scms_pkg::CMD_LEN) begin
            op         = shift_acc[7:0];
            slot_count = '0;
            shift_acc  = '0;
            case (op)
              scms_pkg::CMD_STATUS: bus_phase = scms_pkg::PH_STATUS;
              scms_pkg::CMD_ADDR24: bus_phase = scms_pkg::PH_ADDR24;
              scms_pkg::CMD_ADDR16: bus_phase = scms_pkg::PH_ADDR16;
              scms_pkg::CMD_READ_A,
              scms_pkg::CMD_READ_B: bus_phase = scms_pkg::PH_READ;
              default: begin
                err_sticky = 1'b1;
                bus_phase  = scms_pkg::PH_WAIT;
              end
            endcase
          end
        end
        scms_pkg::PH_ADDR16, scms_pkg::PH_ADDR24: begin
          need = (bus_phase == scms_pkg::PH_ADDR24) ? scms_pkg::ADDR24_LEN
                                                    : scms_pkg::ADDR16_LEN;
          shift_acc  = {shift_acc[scms_pkg::SHIFT_BITS-2:0], din};
          slot_count = slot_count + 5'd1;
          if (slot_count >= need) begin
            read_ptr   = shift_acc;
            slot_count = '0;
            shift_acc  = '0;
            bus_phase  = scms_pkg::PH_WAIT;
            addr_loads++;
          end
        end
        scms_pkg::PH_STATUS: begin
          if (slot_count == '0) tx_shift = scms_pkg::STATUS_BYTE;
          r.data_out   = tx_shift[7];
          r.data_drive = 1'b1;
          tx_shift     = {tx_shift[6:0], 1'b0};
          slot_count   = slot_count + 5'd1;
          if (slot_count >= scms_pkg::BYTE_LEN) begin
            slot_count = '0;
            bus_phase  = scms_pkg::PH_WAIT;
          end
        end
        scms_pkg::PH_READ: begin
          // pointer steps at the start of every byte, even one cut short
          if (slot_count == '0) begin
            tx_shift = mem;
            read_ptr = read_ptr + 24'd1;
            read_bytes++;
          end
          r.data_out   = tx_shift[7];
          r.data_drive = 1'b1;
          tx_shift     = {tx_shift[6:0], 1'b0};
          slot_count   = slot_count + 5'd1;
          if (slot_count >= scms_pkg::BYTE_LEN) slot_count = '0;
        end
        default: ignored_slots++;
      endcase
    end
    r.mem_address = read_ptr;
    r.led_on      = (bus_phase != scms_pkg::PH_READ);
    r.error       = err_sticky;
    expected_slots.push_back(r);
  endfunction

  // Called and returning at a falling edge; leaves in_valid high
  task automatic send_slot(input logic kind, input logic din);
    logic [7:0] mem;
    if (src_gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    // mostly behave like a memory behind the shown address
    if ($urandom_range(0, 3) == 0) mem = 8'($urandom);
    else mem = read_ptr[7:0] ^ {read_ptr[12:8], read_ptr[23:21]} ^ 8'h3C;
    in_valid <= 1'b1;
    command  <= kind;
    data_in  <= din;
    mem_data <= mem;
    do @(posedge clk); while (!in_ready);
    predict_slot(kind, din, mem);
    slots_sent++;
    if (kind == EV_RELEASE) releases_sent++;
    @(negedge clk);
  endtask

  task automatic send_bits(input logic [23:0] value, input int unsigned nbits);
    for (int i = int'(nbits) - 1; i >= 0; i--) send_slot(EV_SLOT, value[i]);
  endtask

  task automatic send_random_slots(input int unsigned n);
    repeat (n) send_slot(EV_SLOT, 1'($urandom_range(0, 1)));
  endtask

  // Hold off the sender until every queued result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_slots.size() != 0);
  endtask

  task automatic test_status_reply();
    send_bits(scms_pkg::CMD_STATUS, scms_pkg::CMD_LEN);
    // two extra slots after the byte are ignored
    send_random_slots(scms_pkg::BYTE_LEN + 2);
    send_slot(EV_RELEASE, 1'b1);
  endtask

  task automatic test_address_load();
    send_bits(scms_pkg::CMD_ADDR16, scms_pkg::CMD_LEN);
    send_bits(24'h00FFFF, scms_pkg::ADDR16_LEN);
    send_slot(EV_RELEASE, 1'b0);
    send_bits(scms_pkg::CMD_ADDR24, scms_pkg::CMD_LEN);
    send_bits(24'hFFFFFF, scms_pkg::ADDR24_LEN);
    send_slot(EV_RELEASE, 1'b1);
  endtask

  task automatic test_read_stream();
    // pointer wraps past the top on the first byte
    send_bits(scms_pkg::CMD_READ_B, scms_pkg::CMD_LEN);
    send_random_slots(12);
    send_slot(EV_RELEASE, 1'b0);
    send_bits(scms_pkg::CMD_READ_A, scms_pkg::CMD_LEN);
    send_random_slots(scms_pkg::BYTE_LEN);
    send_slot(EV_RELEASE, 1'b1);
  endtask

  task automatic test_unknown_command();
    send_bits(CMD_LIST, scms_pkg::CMD_LEN);
    send_random_slots(3);
    send_slot(EV_RELEASE, 1'b0);
    send_bits(CMD_OPEN, scms_pkg::CMD_LEN);
    send_slot(EV_RELEASE, 1'b1);
    send_bits(scms_pkg::CMD_STATUS, scms_pkg::CMD_LEN);
    send_random_slots(scms_pkg::BYTE_LEN);
    send_slot(EV_RELEASE, 1'b0);
  endtask

  task automatic test_early_release();
    send_slot(EV_RELEASE, 1'b1);
    send_random_slots(3);
    send_slot(EV_RELEASE, 1'b0);
    send_bits(scms_pkg::CMD_ADDR24, scms_pkg::CMD_LEN);
    send_bits(24'h5A5A5A, 10);
    send_slot(EV_RELEASE, 1'b1);
    send_bits(scms_pkg::CMD_ADDR16, scms_pkg::CMD_LEN);
    send_bits(24'h000000, scms_pkg::ADDR16_LEN);
    send_slot(EV_RELEASE, 1'b0);
  endtask

  task automatic test_random_traffic();
    int unsigned base, done, roll, need, n;
    logic [23:0] addr;
    logic [7:0]  op;
    base = slots_sent;
    done = 0;
    while (done < RANDOM_ITEMS) begin
      // finish the run with both sides running flat out
      if (done > RANDOM_ITEMS * 4 / 5) begin
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        if (src_gaps_on) wait_drained();
      end else if (roll < 18) begin
        send_bits(scms_pkg::CMD_STATUS, scms_pkg::CMD_LEN);
        send_random_slots($urandom_range(0, 12));
        send_slot(EV_RELEASE, 1'($urandom_range(0, 1)));
      end else if (roll < 38) begin
        op   = $urandom_range(0, 1) ? scms_pkg::CMD_ADDR24 : scms_pkg::CMD_ADDR16;
        need = (op == scms_pkg::CMD_ADDR24) ? scms_pkg::ADDR24_LEN : scms_pkg::ADDR16_LEN;
        case ($urandom_range(0, 5))
          0:       addr = '0;
          1:       addr = '1;
          2:       addr = 24'hFFFFFF - 24'($urandom_range(0, 3));
          default: addr = 24'($urandom);
        endcase
        send_bits(op, scms_pkg::CMD_LEN);
        if ($urandom_range(0, 9) == 0) begin
          send_bits(addr, $urandom_range(1, need - 1));
        end else begin
          send_bits(addr, need);
          send_random_slots($urandom_range(0, 2));
        end
        send_slot(EV_RELEASE, 1'($urandom_range(0, 1)));
      end else if (roll < 72) begin
        op = $urandom_range(0, 1) ? scms_pkg::CMD_READ_A : scms_pkg::CMD_READ_B;
        if ($urandom_range(0, 19) == 0) n = $urandom_range(40, 96);
        else n = $urandom_range(0, 30);
        send_bits(op, scms_pkg::CMD_LEN);
        send_random_slots(n);
        send_slot(EV_RELEASE, 1'($urandom_range(0, 1)));
      end else if (roll < 80) begin
        if ($urandom_range(0, 3) == 0) begin
          op = $urandom_range(0, 1) ? CMD_LIST : CMD_OPEN;
        end else begin
          do op = 8'($urandom);
          while (op inside {scms_pkg::CMD_STATUS, scms_pkg::CMD_ADDR24,
                            scms_pkg::CMD_ADDR16, scms_pkg::CMD_READ_A,
                            scms_pkg::CMD_READ_B});
        end
        send_bits(op, scms_pkg::CMD_LEN);
        send_random_slots($urandom_range(0, 6));
        send_slot(EV_RELEASE, 1'($urandom_range(0, 1)));
      end else if (roll < 90) begin
        send_random_slots($urandom_range(1, 7));
        send_slot(EV_RELEASE, 1'($urandom_range(0, 1)));
      end else begin
        repeat ($urandom_range(1, 6))
          send_slot(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 1) == 1) send_slot(EV_RELEASE, 1'b0);
      end
      done = slots_sent - base;
    end
  endtask

  // Receiver: random stall bursts while enabled
  initial begin : sink_proc
    int unsigned hold;
    hold = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold != 0) hold--;
      else if (sink_stalls_on && $urandom_range(0, 4) == 0) hold = $urandom_range(1, 9);
      out_ready <= (hold == 0);
    end
  end

  always @(posedge clk) begin : check_proc
    slot_result_t want;
    slot_result_t got;
    if (!rst && out_valid && out_ready) begin
      results_checked++;
      got = '{data_out, data_drive, mem_address, led_on, error};
      if (expected_slots.size() == 0) begin
        if (mismatches < 10)
          $display("Unexpected result %0d: out=%b drive=%b addr=%06h led=%b err=%b",
                   results_checked, got.data_out, got.data_drive, got.mem_address,
                   got.led_on, got.error);
        mismatches++;
      end else begin
        want = expected_slots.pop_front();
        if (got !== want) begin
          if (mismatches < 10) begin
            $display("Mismatch at result %0d: expected out=%b drive=%b addr=%06h led=%b err=%b",
                     results_checked, want.data_out, want.data_drive, want.mem_address,
                     want.led_on, want.error);
            $display("  got out=%b drive=%b addr=%06h led=%b err=%b",
                     got.data_out, got.data_drive, got.mem_address, got.led_on,
                     got.error);
          end
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
             expected_slots.size());
    $display("FAIL serial_cartridge_memory_slave");
    $finish;
  end

  initial begin : stimulus
    rst      = 1'b1;
    in_valid = 1'b0;
    command  = EV_SLOT;
    data_in  = 1'b0;
    mem_data = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_status_reply();
    test_address_load();
    test_read_stream();
    test_unknown_command();
    test_early_release();
    wait_drained();
    test_random_traffic();

    in_valid <= 1'b0;
    do @(negedge clk); while (expected_slots.size() != 0);
    repeat (10) @(posedge clk);

    $display("Covered %0d bus slots (%0d select releases, %0d ignored), %0d address loads,",
             slots_sent, releases_sent, ignored_slots, addr_loads);
    $display("%0d read bytes started; %0d results checked, %0d mismatches.",
             read_bytes, results_checked, mismatches);
    if (mismatches == 0) begin
      $display("PASS serial_cartridge_memory_slave");
    end else begin
      $display("FAIL serial_cartridge_memory_slave");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/scms_pkg.sv
sv/scms_engine.sv
sv/serial_cartridge_memory_slave.sv
sv/scms_checker.sv
tb/tb_top.sv
